// ----- sv/mexp_pkg.sv -----
// Shared constants and types for the modular exponentiation core.
// No dependencies.
package mexp_pkg;

   localparam int WIDTH     = 32;
   localparam int CNT_WIDTH = $clog2(WIDTH);

   typedef logic [WIDTH-1:0] word_type;

endpackage

// ----- sv/mexp_mulmod.sv -----
// Bit-serial modular multiplier: product = a * b mod m, one bit of b per cycle.
// Depends on mexp_pkg. Requires a < m and m held stable while busy.
module mexp_mulmod (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  mexp_pkg::word_type a,
   input  mexp_pkg::word_type b,
   input  mexp_pkg::word_type m,
   output logic              done,
   output mexp_pkg::word_type product
);
   import mexp_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   word_type             acc_ff, acc_in;
   word_type             a_ff, a_in;
   word_type             b_ff, b_in;

   logic [WIDTH+1:0] sum;
   logic [WIDTH+1:0] m_ext;
   logic [WIDTH+1:0] m2_ext;
   logic [WIDTH+1:0] reduced;

   always_comb begin
      m_ext  = (WIDTH+2)'(m);
      m2_ext = {1'b0, m, 1'b0};
      sum    = {1'b0, acc_ff, 1'b0} + (b_ff[WIDTH-1] ? (WIDTH+2)'(a_ff) : '0);
      if (sum >= m2_ext) begin
         reduced = sum - m2_ext;
      end else if (sum >= m_ext) begin
         reduced = sum - m_ext;
      end else begin
         reduced = sum;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         a_in    = a;
         b_in    = b;
      end else if (busy_ff) begin
         acc_in = reduced[WIDTH-1:0];
         b_in   = {b_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_WIDTH'(WIDTH-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

`ifndef SYNTHESIS
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("mulmod started while busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("mulmod done while still busy");
   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && $stable(m) && a_ff < m) |=> (acc_ff < m || !$stable(m)))
      else $error("mulmod accumulator not reduced");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("mulmod did not go busy");
`endif

endmodule

// ----- sv/modular_exponentiation_core.sv -----
// Modular exponentiation core: base ** exponent mod modulus, right-to-left binary.
// Depends on mexp_pkg and mexp_mulmod (two instances: result and square).
//
// Usage: the request channel (req_valid/req_stall) carries base, exponent and
// modulus; the response channel (rsp_valid/rsp_stall) carries one result per
// request. A transfer happens on a rising edge with valid high and stall low.
// One request is in work at a time; req_stall is high while it is in work.
// Zero base, zero exponent or zero modulus go straight to the finish
// state. Otherwise the base is first reduced by one serial multiply, then
// each exponent bit up to the highest set bit costs one pass of the two
// serial multipliers running side by side, and the finish state hands the
// result to the output register. The run time is set by the bit-serial
// multiplier, one multiplier bit a cycle.
// The result sits in an output register: a new request is taken while a
// finished result is still stalled; if the next result finishes before the
// previous one is taken, the core waits until the output register frees.
// Reset (synchronous, active high) drops any request in work and rsp_valid.
module modular_exponentiation_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_base_value,
   input  logic [31:0] req_exponent,
   input  logic [31:0] req_modulus,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_power_result
);
   import mexp_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_RED_GO  = 3'd1;
   localparam logic [2:0] ST_RED_WT  = 3'd2;
   localparam logic [2:0] ST_SQ_GO   = 3'd3;
   localparam logic [2:0] ST_SQ_WT   = 3'd4;
   localparam logic [2:0] ST_FINISH  = 3'd5;

   logic [2:0]  state_ff, state_in;
   word_type    base_ff, base_in;
   word_type    exp_ff, exp_in;
   word_type    mod_ff, mod_in;
   word_type    result_ff, result_in;
   word_type    square_ff, square_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;

   logic [63:0] base_wide, exp_wide, mod_wide, result_wide;
   logic        req_xfer;
   logic        start_r, start_s;
   word_type    r_a, r_b;
   logic        r_done, s_done;
   word_type    r_prod, s_prod;

   assign base_wide   = 64'(req_base_value);
   assign exp_wide    = 64'(req_exponent);
   assign mod_wide    = 64'(req_modulus);
   assign result_wide = 64'(result_ff);

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;

   assign start_r = (state_ff == ST_RED_GO) || (state_ff == ST_SQ_GO);
   assign start_s = (state_ff == ST_SQ_GO);
   assign r_a     = (state_ff == ST_RED_GO) ? WIDTH'(1) : result_ff;
   assign r_b     = (state_ff == ST_RED_GO) ? base_ff : square_ff;

   mexp_mulmod u_mul_r (
      .clock   (clock),
      .reset   (reset),
      .start   (start_r),
      .a       (r_a),
      .b       (r_b),
      .m       (mod_ff),
      .done    (r_done),
      .product (r_prod)
   );

   mexp_mulmod u_mul_s (
      .clock   (clock),
      .reset   (reset),
      .start   (start_s),
      .a       (square_ff),
      .b       (square_ff),
      .m       (mod_ff),
      .done    (s_done),
      .product (s_prod)
   );

   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      mod_in       = mod_ff;
      result_in    = result_ff;
      square_in    = square_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               base_in = base_wide[WIDTH-1:0];
               exp_in  = exp_wide[WIDTH-1:0];
               mod_in  = mod_wide[WIDTH-1:0];
               if (base_wide[WIDTH-1:0] == '0) begin
                  result_in = '0;
                  state_in  = ST_FINISH;
               end else if (exp_wide[WIDTH-1:0] == '0) begin
                  result_in = WIDTH'(1);
                  state_in  = ST_FINISH;
               end else if (mod_wide[WIDTH-1:0] == '0) begin
                  result_in = '0;
                  state_in  = ST_FINISH;
               end else begin
                  state_in = ST_RED_GO;
               end
            end
         end
         ST_RED_GO: begin
            state_in = ST_RED_WT;
         end
         ST_RED_WT: begin
            if (r_done) begin
               square_in = r_prod;
               result_in = (mod_ff == WIDTH'(1)) ? '0 : WIDTH'(1);
               state_in  = ST_SQ_GO;
            end
         end
         ST_SQ_GO: begin
            state_in = ST_SQ_WT;
         end
         ST_SQ_WT: begin
            if (s_done) begin
               if (exp_ff[0]) begin
                  result_in = r_prod;
               end
               square_in = s_prod;
               exp_in    = exp_ff >> 1;
               state_in  = ((exp_ff >> 1) == '0) ? ST_FINISH : ST_SQ_GO;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_wide[31:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff     <= base_in;
      exp_ff      <= exp_in;
      mod_ff      <= mod_in;
      result_ff   <= result_in;
      square_ff   <= square_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_data_ff;

`ifndef SYNTHESIS
   a_mul_nonzero_mod: assert property (@(posedge clock) disable iff (reset)
      start_r |-> (mod_ff != '0))
      else $error("multiply started with zero modulus");
   a_units_in_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQ_WT) |-> (r_done == s_done))
      else $error("result and square multipliers out of step");
   a_operands_reduced: assert property (@(posedge clock) disable iff (reset)
      start_s |-> (square_ff < mod_ff && result_ff < mod_ff))
      else $error("multiplier operand not reduced");
`endif

endmodule
